@@ src/frle_pkg.sv @@
// Shared types, constants and code tables of the fax run-length encoder.
package frle_pkg;

  localparam int RUN_BITS = 16;
  localparam int ACC_W    = 20;
  localparam int CNT_W    = 5;

  typedef enum logic [1:0] {
    ACT_RUN  = 2'd0,
    ACT_EOL  = 2'd1,
    ACT_RTC  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] run_length;
    logic        is_black;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic load;
    logic emit;
    logic flush;
  } frle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic ge8;
    logic done;
    logic room;
    logic hold_vld;
  } frle_sts_t;

  // entries: {length[3:0], code[7:0]}
  localparam logic [11:0] EOL_CODE = 12'hC01;

  localparam logic [11:0] WHITE_TERM [64] = '{
    12'h835, 12'h607, 12'h407, 12'h408, 12'h40B, 12'h40C, 12'h40E, 12'h40F,
    12'h513, 12'h514, 12'h507, 12'h508, 12'h608, 12'h603, 12'h634, 12'h635,
    12'h62A, 12'h62B, 12'h727, 12'h70C, 12'h708, 12'h717, 12'h703, 12'h704,
    12'h728, 12'h72B, 12'h713, 12'h724, 12'h718, 12'h802, 12'h803, 12'h81A,
    12'h81B, 12'h812, 12'h813, 12'h814, 12'h815, 12'h816, 12'h817, 12'h828,
    12'h829, 12'h82A, 12'h82B, 12'h82C, 12'h82D, 12'h804, 12'h805, 12'h80A,
    12'h80B, 12'h852, 12'h853, 12'h854, 12'h855, 12'h824, 12'h825, 12'h858,
    12'h859, 12'h85A, 12'h85B, 12'h84A, 12'h84B, 12'h832, 12'h833, 12'h834
  };

  localparam logic [11:0] BLACK_TERM [64] = '{
    12'hA37, 12'h302, 12'h203, 12'h202, 12'h303, 12'h403, 12'h402, 12'h503,
    12'h605, 12'h604, 12'h704, 12'h705, 12'h707, 12'h804, 12'h807, 12'h918,
    12'hA17, 12'hA18, 12'hA08, 12'hB67, 12'hB68, 12'hB6C, 12'hB37, 12'hB28,
    12'hB17, 12'hB18, 12'hCCA, 12'hCCB, 12'hCCC, 12'hCCD, 12'hC68, 12'hC69,
    12'hC6A, 12'hC6B, 12'hCD2, 12'hCD3, 12'hCD4, 12'hCD5, 12'hCD6, 12'hCD7,
    12'hC6C, 12'hC6D, 12'hCDA, 12'hCDB, 12'hC54, 12'hC55, 12'hC56, 12'hC57,
    12'hC64, 12'hC65, 12'hC52, 12'hC53, 12'hC24, 12'hC37, 12'hC38, 12'hC27,
    12'hC28, 12'hC58, 12'hC59, 12'hC2B, 12'hC2C, 12'hC5A, 12'hC66, 12'hC67
  };

  localparam logic [11:0] WHITE_MAKEUP [27] = '{
    12'h51B, 12'h512, 12'h617, 12'h737, 12'h836, 12'h837, 12'h864, 12'h865,
    12'h868, 12'h867, 12'h9CC, 12'h9CD, 12'h9D2, 12'h9D3, 12'h9D4, 12'h9D5,
    12'h9D6, 12'h9D7, 12'h9D8, 12'h9D9, 12'h9DA, 12'h9DB, 12'h998, 12'h999,
    12'h99A, 12'h618, 12'h99B
  };

  localparam logic [11:0] BLACK_MAKEUP [27] = '{
    12'hA0F, 12'hCC8, 12'hCC9, 12'hC5B, 12'hC33, 12'hC34, 12'hC35, 12'hD6C,
    12'hD6D, 12'hD4A, 12'hD4B, 12'hD4C, 12'hD4D, 12'hD72, 12'hD73, 12'hD74,
    12'hD75, 12'hD76, 12'hD77, 12'hD52, 12'hD53, 12'hD54, 12'hD55, 12'hD5A,
    12'hD5B, 12'hD64, 12'hD65
  };

  localparam logic [11:0] EXT_MAKEUP [13] = '{
    12'hB08, 12'hB0C, 12'hB0D, 12'hC12, 12'hC13, 12'hC14, 12'hC15,
    12'hC16, 12'hC17, 12'hC1C, 12'hC1D, 12'hC1E, 12'hC1F
  };

endpackage

@@ src/fax_run_length_huffman_encoder.sv @@
// Top level of the fax run-length (Modified Huffman) encoder.
//
//   channel | signals                              | word
//   in      | in_valid_i, in_stall_o, in_data_i    | action, run_length, is_black
//   out     | out_valid_o, out_stall_i, out_data_o | out_byte, last
//
// One item at a time. An item is accepted in the idle state; each code is then
// loaded in the code state, and the emit state drains its completed bytes, then
// checks whether the item is done; a flush ends it. An unused action goes back
// to idle from the code state. The single bit packer and its one-byte-per-cycle
// drain, while the output has room, set the rate. Reset clears the pending bits;
// leftover bits under a byte carry to later items. A stalled output holds the
// packer; the last byte of an item waits in a hold register so it can carry last.
module fax_run_length_huffman_encoder
  import frle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  frle_cmd_t cmd;
  frle_sts_t sts;

  frle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/frle_ctrl.sv @@
// Controller state machine of the fax run-length encoder.
module frle_ctrl
  import frle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  frle_sts_t sts_i,
  output frle_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CODE  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // sequence codes and byte emission
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_CODE;
        end
      end
      ST_CODE: begin
        if (sts_i.skip) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.ge8) begin
          if (!sts_i.hold_vld || sts_i.room) cmd_o.emit = 1'b1;
        end else if (sts_i.done) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_CODE;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.hold_vld || sts_i.room) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/frle_dp.sv @@
// Datapath of the fax run-length encoder: code lookup, bit packer, output word.
module frle_dp
  import frle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  frle_cmd_t cmd_i,
  output frle_sts_t sts_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [RUN_BITS-1:0] run_q;
  logic                black_q;
  logic [1:0]          action_q;
  logic                done_q;
  logic                fill_q;
  logic [2:0]          eol_left_q;
  logic [7:0]          hold_q;
  logic                hold_vld_q;
  logic                out_vld_q;
  out_item_t           out_q;

  logic [RUN_BITS-7:0] mult;
  logic [5:0]          nsel;
  logic                is_makeup;
  logic                is_fill;
  logic [11:0]         entry;
  logic [3:0]          len;
  logic [7:0]          code;
  logic [CNT_W-1:0]    shamt;
  logic [7:0]          new_byte;
  logic                room;

  // pick the next code of the item
  always_comb begin
    mult      = run_q[RUN_BITS-1:6];
    nsel      = (mult > (RUN_BITS-6)'(40)) ? 6'd40 : mult[5:0];
    is_makeup = (run_q > RUN_BITS'(63));
    is_fill   = fill_q && (cnt_q != '0);
    entry     = EOL_CODE;
    unique case (action_q)
      ACT_RUN: begin
        if (is_makeup) begin
          if (nsel <= 6'd27) begin
            entry = black_q ? BLACK_MAKEUP[5'(nsel - 6'd1)] : WHITE_MAKEUP[5'(nsel - 6'd1)];
          end else begin
            entry = EXT_MAKEUP[4'(nsel - 6'd28)];
          end
        end else begin
          entry = black_q ? BLACK_TERM[run_q[5:0]] : WHITE_TERM[run_q[5:0]];
        end
      end
      ACT_RTC: begin
        if (is_fill) entry = {4'(5'd8 - cnt_q), 8'h00};
      end
      default: entry = EOL_CODE;
    endcase
    len  = entry[11:8];
    code = entry[7:0];
  end

  assign shamt    = cnt_q - CNT_W'(8);
  assign new_byte = 8'(acc_q >> shamt);
  assign room     = !out_vld_q || !out_stall_i;

  assign sts_o.skip     = (action_q == ACT_NONE);
  assign sts_o.ge8      = (cnt_q >= CNT_W'(8));
  assign sts_o.done     = done_q;
  assign sts_o.room     = room;
  assign sts_o.hold_vld = hold_vld_q;

  // pack code bits, drain whole bytes
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      acc_d = (acc_q << len) | ACC_W'(code);
      cnt_d = cnt_q + CNT_W'(len);
    end else if (cmd_i.emit) begin
      cnt_d = shamt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      cnt_q      <= '0;
      action_q   <= ACT_NONE;
      done_q     <= 1'b0;
      fill_q     <= 1'b0;
      eol_left_q <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;

      // latch the command word
      if (cmd_i.start) begin
        action_q   <= in_data_i.action;
        done_q     <= 1'b0;
        fill_q     <= 1'b1;
        eol_left_q <= 3'd6;
      end

      // advance through the code sequence
      if (cmd_i.load) begin
        unique case (action_q)
          ACT_RUN: begin
            if (!is_makeup) done_q <= 1'b1;
          end
          ACT_RTC: begin
            fill_q <= 1'b0;
            if (!is_fill) begin
              eol_left_q <= eol_left_q - 3'd1;
              if (eol_left_q == 3'd1) done_q <= 1'b1;
            end
          end
          default: done_q <= 1'b1;
        endcase
      end

      // output word handshake
      if ((cmd_i.emit || cmd_i.flush) && hold_vld_q) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end

      if (cmd_i.emit) begin
        hold_vld_q <= 1'b1;
      end else if (cmd_i.flush) begin
        hold_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      run_q   <= in_data_i.run_length[RUN_BITS-1:0];
      black_q <= in_data_i.is_black;
    end else if (cmd_i.load && action_q == ACT_RUN && is_makeup) begin
      run_q <= run_q - RUN_BITS'({nsel, 6'b0});
    end
    if (cmd_i.emit) hold_q <= new_byte;
    if ((cmd_i.emit || cmd_i.flush) && hold_vld_q) begin
      out_q.out_byte <= hold_q;
      out_q.last     <= cmd_i.flush;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ test/tb_fax_run_length_huffman_encoder.sv @@
// Testbench of the fax run-length Huffman encoder: directed table plus random commands.
`timescale 1ns / 1ps

module tb_fax_run_length_huffman_encoder;
  import frle_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  fax_run_length_huffman_encoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // directed row; has_exp marks a byte typed in by hand
  typedef struct {
    in_item_t   word;
    logic       has_exp;
    out_item_t  exp_first;
  } row_t;

  out_item_t  byte_q[$];
  logic [6:0] pend_bits;
  int         pend_cnt;
  int         n_bytes;
  int         n_err;
  bit         stim_done;
  bit         long_hold;

  // pack one code into the pending bits, queue every completed byte
  function automatic void pack_code(input logic [12:0] code, input int len);
    logic [31:0] acc;
    int          cnt;
    out_item_t   ob;
    acc = ({25'd0, pend_bits} << len) | {19'd0, code};
    cnt = pend_cnt + len;
    while (cnt >= 8) begin
      ob.out_byte = acc[cnt-1 -: 8];
      ob.last     = 1'b0;
      byte_q.push_back(ob);
      n_bytes++;
      cnt -= 8;
      acc &= (32'd1 << cnt) - 1;
    end
    pend_bits = acc[6:0];
    pend_cnt  = cnt;
  endfunction

  function automatic void pack_entry(input logic [11:0] e);
    pack_code({5'd0, e[7:0]}, int'(e[11:8]));
  endfunction

  // encode one command into expected bytes
  function automatic void encode_word(input in_item_t w);
    int run;
    int n;
    n_bytes = 0;
    case (action_e'(w.action))
      ACT_RUN: begin
        run = int'(w.run_length);
        while (run > 63) begin
          n = run / 64;
          if (n > 40) n = 40;
          if (n <= 27) begin
            pack_entry(w.is_black ? BLACK_MAKEUP[5'(n-1)] : WHITE_MAKEUP[5'(n-1)]);
          end else begin
            pack_entry(EXT_MAKEUP[4'(n-28)]);
          end
          run -= n * 64;
        end
        pack_entry(w.is_black ? BLACK_TERM[6'(run)] : WHITE_TERM[6'(run)]);
      end
      ACT_EOL: pack_code(13'd1, 12);
      ACT_RTC: begin
        if (pend_cnt != 0) pack_code(13'd0, 8 - pend_cnt);
        for (int i = 0; i < 6; i++) pack_code(13'd1, 12);
      end
      default: ;
    endcase
    if (n_bytes > 0) byte_q[$].last = 1'b1;
  endfunction

  // send one word, wait for acceptance
  task automatic send_word(input in_item_t w);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_word(w);
  endtask

  task automatic idle_in();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic in_item_t rand_word();
    in_item_t w;
    int       r;
    w.action     = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 7) w.action = ACT_RUN;
    w.is_black   = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 9);
    if (r < 6) w.run_length = 16'($urandom_range(0, 63));
    else if (r < 9) w.run_length = 16'($urandom_range(64, 2600));
    else w.run_length = 16'($urandom);
    return w;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // timeout
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stalls, one long hold on request
  initial begin
    int g;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0) g = 0;
      out_stall_i <= (g > 0);
      repeat (g > 0 ? g : 1) @(posedge clk_i);
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  end

  // check every accepted byte against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t ex;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (byte_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected byte %h last %b", out_data_o.out_byte,
                                  out_data_o.last);
      end else begin
        ex = byte_q.pop_front();
        if (ex.out_byte !== out_data_o.out_byte || ex.last !== out_data_o.last) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: exp %h/%b got %h/%b", ex.out_byte, ex.last,
                                    out_data_o.out_byte, out_data_o.last);
        end
      end
    end
  end

  // stimulus
  initial begin
    row_t        tbl[$];
    row_t        rw;
    in_item_t    w;
    int          wait_cnt;
    logic [15:0] runs [11];
    logic [6:0]  sv_bits;
    int          sv_cnt;
    int          sv_size;
    n_err = 0; pend_bits = '0; pend_cnt = 0; long_hold = 1'b0; stim_done = 1'b0;
    rst_ni = 1'b0; in_valid_i <= 1'b0; in_data_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // after reset: white zero is 00110101 -> one byte 0x35, last
    rw.word = '{ACT_RUN, 16'd0, 1'b0}; rw.has_exp = 1; rw.exp_first = '{8'h35, 1'b1};
    tbl.push_back(rw);
    // aligned: EOL leaves 4 bits, byte 0x00
    rw.word = '{ACT_EOL, 16'hFFFF, 1'b1}; rw.has_exp = 1; rw.exp_first = '{8'h00, 1'b1};
    tbl.push_back(rw);
    rw.has_exp = 0;
    runs = '{16'd0, 16'd1, 16'd63, 16'd64, 16'd1727, 16'd1728, 16'd1792, 16'd2560,
             16'd2623, 16'd5000, 16'hFFFF};
    for (int k = 0; k < 11; k++) begin
      rw.word = '{ACT_RUN, runs[k], 1'b0}; tbl.push_back(rw);
      rw.word = '{ACT_RUN, runs[k], 1'b1}; tbl.push_back(rw);
    end
    rw.word = '{ACT_NONE, 16'hFFFF, 1'b1}; tbl.push_back(rw);
    rw.word = '{ACT_RTC, 16'h0, 1'b0}; tbl.push_back(rw);
    rw.word = '{ACT_RTC, 16'hFFFF, 1'b1}; tbl.push_back(rw);

    foreach (tbl[i]) begin
      if (tbl[i].has_exp) begin
        // predict the row, compare its first byte, then roll the prediction back
        sv_bits = pend_bits; sv_cnt = pend_cnt; sv_size = byte_q.size();
        encode_word(tbl[i].word);
        if (byte_q.size() <= sv_size || byte_q[sv_size] !== tbl[i].exp_first) begin
          n_err++;
          if (n_err <= 10) $display("table row %0d: exp %h/%b", i, tbl[i].exp_first.out_byte,
                                    tbl[i].exp_first.last);
        end
        pend_bits = sv_bits; pend_cnt = sv_cnt;
        while (byte_q.size() > sv_size) void'(byte_q.pop_back());
      end
      send_word(tbl[i].word);
      idle_in();
    end

    // random part; sender pause and long receiver hold midway
    for (int j = 0; j < 104; j++) begin
      if (j == 40) begin
        in_valid_i <= 1'b0;
        wait_cnt = 0;
        while (byte_q.size() > 0 && wait_cnt < 100000) begin
          @(posedge clk_i); wait_cnt++;
        end
      end
      if (j == 80) long_hold = 1'b1;
      w = rand_word();
      send_word(w);
      if (j < 80 || j > 100) idle_in();
    end
    in_valid_i <= 1'b0;

    wait_cnt = 0;
    while (byte_q.size() > 0 && wait_cnt < 200000) begin
      @(posedge clk_i); wait_cnt++;
    end
    repeat (100) @(posedge clk_i);
    if (n_err == 0 && byte_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
